### rtl/pcif_pkg.sv
// Package with shared constants, types and tables of the pc instrumentation filter.
`timescale 1ns / 1ps

package pcif_pkg;

	localparam int unsigned NUM_RANGES    = 16;
	localparam int unsigned MAP_SIZE_BITS = 16;

	localparam int unsigned ADDR_W      = 64;
	localparam int unsigned HALF_W      = 32;
	localparam int unsigned ENTRY_IDX_W = 4;
	localparam int unsigned RATIO_W     = 7;
	localparam int unsigned BUCKET_W    = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 64;

	localparam logic [ADDR_W-1:0] MIX_MUL = 64'h9FB2_1C65_1E98_DF25;
	localparam int unsigned ROT_A    = 49;
	localparam int unsigned ROT_B    = 24;
	localparam int unsigned MIX_SHR1 = 35;
	localparam logic [ADDR_W-1:0] MIX_ADD = 64'd8;
	localparam int unsigned MIX_SHR2 = 28;

	localparam int unsigned PctFull   = 100;
	localparam int unsigned RATIO_CNT = 2 ** RATIO_W;

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(PctFull);

	localparam logic [ADDR_W-1:0] BUCKET_MASK = (64'd1 << MAP_SIZE_BITS) - 64'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CODE_START = 2'd0,
		CFG_CODE_END   = 2'd1,
		CFG_INST_RATIO = 2'd2
	} cfg_reg_e;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic [MAP_SIZE_BITS:0] thr_t;
	typedef thr_t thr_tbl_t [RATIO_CNT];

	// Sampling threshold for every raw ratio code, with the clamp to 1..100 folded in.
	function automatic thr_tbl_t build_thr_tbl();
		thr_tbl_t t;
		longint unsigned r;
		for (int i = 0; i < RATIO_CNT; i++) begin
			r = longint'(i);
			if (r == 0)
				r = 1;
			if (r > PctFull)
				r = PctFull;
			t[i] = thr_t'(((64'd1 << MAP_SIZE_BITS) * r) / PctFull);
		end
		return t;
	endfunction

	localparam thr_tbl_t THR_TBL = build_thr_tbl();

endpackage

### rtl/pcif_req_if.sv
// Request channel interface carrying load and query transactions.
`timescale 1ns / 1ps

interface pcif_req_if;
	logic                               valid;
	logic                               ready;
	logic                               req_type;
	logic [pcif_pkg::ENTRY_IDX_W-1:0]   entry_index;
	logic [pcif_pkg::ADDR_W-1:0]        range_start;
	logic [pcif_pkg::ADDR_W-1:0]        range_end;
	logic                               range_exclude;
	logic                               range_valid;
	logic [pcif_pkg::ADDR_W-1:0]        pc;

	modport source (
		output valid, req_type, entry_index, range_start, range_end,
			range_exclude, range_valid, pc,
		input  ready
	);

	modport sink (
		input  valid, req_type, entry_index, range_start, range_end,
			range_exclude, range_valid, pc,
		output ready
	);
endinterface

### rtl/pcif_rsp_if.sv
// Result channel interface carrying query verdict transactions.
`timescale 1ns / 1ps

interface pcif_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            instrumented;
	logic                            ratio_keep;
	logic [pcif_pkg::BUCKET_W-1:0]   hash_bucket;

	modport source (
		output valid, instrumented, ratio_keep, hash_bucket,
		input  ready
	);

	modport sink (
		input  valid, instrumented, ratio_keep, hash_bucket,
		output ready
	);
endinterface

### rtl/pc_instrumentation_filter.sv
// Top level of the pc instrumentation filter: range table, range verdict and hash sampling pipeline.
`timescale 1ns / 1ps

// A load transaction writes one slot of the range table and produces no result; a query
// transaction produces one result, carried through registers s1 to s5. One transaction is
// accepted in every cycle while the result side keeps up. The range compares against all
// table slots run in parallel in the accept cycle, and the depth comes from the hash, whose
// two 64-bit multiplies are each split into three 32x32 partial products with a register
// after the products and another after their sum. The whole pipeline stalls together when
// a finished result is not taken. Configuration is written through cfg_we, cfg_index and
// cfg_wdata; the user must do so only while no transaction is in flight, unenforced by the block.
module pc_instrumentation_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcif_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcif_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	pcif_req_if.sink                            req,
	pcif_rsp_if.source                          rsp
);

	logic [pcif_pkg::ADDR_W-1:0] code_start_q;
	logic [pcif_pkg::ADDR_W-1:0] code_end_q;
	logic [pcif_pkg::RATIO_W-1:0] inst_ratio_q;

	logic [pcif_pkg::ADDR_W-1:0] start_q [pcif_pkg::NUM_RANGES];
	logic [pcif_pkg::ADDR_W-1:0] end_q   [pcif_pkg::NUM_RANGES];
	logic [pcif_pkg::NUM_RANGES-1:0] excl_q;
	logic [pcif_pkg::NUM_RANGES-1:0] valid_q;

	logic en;
	logic acc;
	logic load_acc;
	logic query_acc;

	logic [pcif_pkg::NUM_RANGES-1:0] excl_hit;
	logic [pcif_pkg::NUM_RANGES-1:0] incl_hit;
	logic [pcif_pkg::NUM_RANGES-1:0] slot_we;
	logic code_hit;
	logic verdict;
	logic [pcif_pkg::ADDR_W-1:0] x_mix;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic inst_s1, inst_s2, inst_s3, inst_s4, inst_s5;
	logic [pcif_pkg::ADDR_W-1:0] x_s1;

	logic [pcif_pkg::ADDR_W-1:0] pll_s2;
	logic [pcif_pkg::HALF_W-1:0] phl_s2, plh_s2;
	logic [pcif_pkg::HALF_W-1:0] p_cross;
	logic [pcif_pkg::ADDR_W-1:0] u_val;
	logic [pcif_pkg::ADDR_W-1:0] w_s3;

	logic [pcif_pkg::ADDR_W-1:0] qll_s4;
	logic [pcif_pkg::HALF_W-1:0] qhl_s4, qlh_s4;
	logic [pcif_pkg::HALF_W-1:0] q_cross;
	logic [pcif_pkg::ADDR_W-1:0] v_val;
	logic [pcif_pkg::ADDR_W-1:0] h_val;
	logic keep;

	logic keep_s5;
	logic [pcif_pkg::BUCKET_W-1:0] bucket_s5;

	assign en        = !vld_s5 || rsp.ready;
	assign req.ready = en;
	assign acc       = req.valid && en;
	assign load_acc  = acc && (req.req_type == pcif_pkg::REQ_LOAD);
	assign query_acc = acc && (req.req_type == pcif_pkg::REQ_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_start_q <= '0;
			code_end_q   <= '0;
			inst_ratio_q <= pcif_pkg::RATIO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pcif_pkg::CFG_CODE_START: code_start_q <= cfg_wdata;
				pcif_pkg::CFG_CODE_END:   code_end_q   <= cfg_wdata;
				pcif_pkg::CFG_INST_RATIO: inst_ratio_q <= cfg_wdata[pcif_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < pcif_pkg::NUM_RANGES; j++) begin
			slot_we[j] = load_acc && (int'(req.entry_index) == j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int j = 0; j < pcif_pkg::NUM_RANGES; j++) begin
				if (slot_we[j])
					valid_q[j] <= req.range_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < pcif_pkg::NUM_RANGES; j++) begin
			if (slot_we[j]) begin
				start_q[j] <= req.range_start;
				end_q[j]   <= req.range_end;
				excl_q[j]  <= req.range_exclude;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < pcif_pkg::NUM_RANGES; j++) begin
			excl_hit[j] = valid_q[j] && excl_q[j]
				&& (req.pc >= start_q[j]) && (req.pc < end_q[j]);
			incl_hit[j] = valid_q[j] && !excl_q[j]
				&& (req.pc >= start_q[j]) && (req.pc < end_q[j]);
		end
	end

	assign code_hit = (req.pc >= code_start_q) && (req.pc < code_end_q);
	assign verdict  = !(|excl_hit) && (code_hit || (|incl_hit));
	assign x_mix    = req.pc
		^ ((req.pc << pcif_pkg::ROT_A) | (req.pc >> (pcif_pkg::ADDR_W - pcif_pkg::ROT_A)))
		^ ((req.pc << pcif_pkg::ROT_B) | (req.pc >> (pcif_pkg::ADDR_W - pcif_pkg::ROT_B)));

	assign p_cross = phl_s2 + plh_s2;
	assign u_val   = pll_s2 + {p_cross, {pcif_pkg::HALF_W{1'b0}}};

	assign q_cross = qhl_s4 + qlh_s4;
	assign v_val   = qll_s4 + {q_cross, {pcif_pkg::HALF_W{1'b0}}};
	assign h_val   = (v_val ^ (v_val >> pcif_pkg::MIX_SHR2)) & pcif_pkg::BUCKET_MASK;
	assign keep    = h_val < pcif_pkg::ADDR_W'(pcif_pkg::THR_TBL[inst_ratio_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= query_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inst_s1 <= verdict;
			x_s1    <= x_mix;

			inst_s2 <= inst_s1;
			pll_s2  <= x_s1[pcif_pkg::HALF_W-1:0] * pcif_pkg::MIX_MUL[pcif_pkg::HALF_W-1:0];
			phl_s2  <= x_s1[pcif_pkg::ADDR_W-1:pcif_pkg::HALF_W]
				* pcif_pkg::MIX_MUL[pcif_pkg::HALF_W-1:0];
			plh_s2  <= x_s1[pcif_pkg::HALF_W-1:0]
				* pcif_pkg::MIX_MUL[pcif_pkg::ADDR_W-1:pcif_pkg::HALF_W];

			inst_s3 <= inst_s2;
			w_s3    <= u_val ^ ((u_val >> pcif_pkg::MIX_SHR1) + pcif_pkg::MIX_ADD);

			inst_s4 <= inst_s3;
			qll_s4  <= w_s3[pcif_pkg::HALF_W-1:0] * pcif_pkg::MIX_MUL[pcif_pkg::HALF_W-1:0];
			qhl_s4  <= w_s3[pcif_pkg::ADDR_W-1:pcif_pkg::HALF_W]
				* pcif_pkg::MIX_MUL[pcif_pkg::HALF_W-1:0];
			qlh_s4  <= w_s3[pcif_pkg::HALF_W-1:0]
				* pcif_pkg::MIX_MUL[pcif_pkg::ADDR_W-1:pcif_pkg::HALF_W];

			inst_s5   <= inst_s4;
			keep_s5   <= keep;
			bucket_s5 <= h_val[pcif_pkg::BUCKET_W-1:0];
		end
	end

	assign rsp.valid        = vld_s5;
	assign rsp.instrumented = inst_s5;
	assign rsp.ratio_keep   = keep_s5;
	assign rsp.hash_bucket  = bucket_s5;

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> !vld_s1)
		else $error("Load transaction entered the result pipeline.");

	a_query_enters: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> vld_s1)
		else $error("Query transaction was lost at the pipeline entry.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && vld_s4) |=> vld_s4)
		else $error("Stalled pipeline stage dropped its transaction.");

	a_stage_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s4) |=> rsp.valid)
		else $error("Query transaction did not reach the output register.");

endmodule
